### hdl/queued_pulse_train_generator_top_assert.svh
// Assertion macros for the queued pulse-train generator.
// Included by the top-level RTL file, which carries concurrent assertions; no other dependencies.
`ifndef QUEUED_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`define QUEUED_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPTG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qptg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qptg assertion failed");

`endif

### hdl/qptg_pkg.sv
// Shared types and constants for the queued pulse-train generator.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package qptg_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TICKS_W = 16;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int QCNT_W  = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = 1'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Send status codes.
  localparam logic [STAT_W-1:0] STAT_NONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEAD     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TICKS_W-1:0] pulse_ticks;
    logic [TIME_W-1:0]  time_us;
  } in_word_t;

  typedef struct packed {
    logic              pin_level;
    logic [STAT_W-1:0] send_status;
    logic [QCNT_W-1:0] queue_count;
  } out_word_t;

endpackage

`default_nettype wire

### hdl/qptg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qptg_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/queued_pulse_train_generator_top.sv
// Queued pulse-train generator, top level.
// Depends on qptg_pkg, qptg_ram and queued_pulse_train_generator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// One item is taken when start is high and busy is low. Its result word appears
// on out_word with out_strobe high for one cycle, in the cycle that follows the
// item's last cycle of work, and must be captured then. A tick that pops a queue
// entry reads it, then applies it in ST_POP, as the queue memory has a registered
// read. An accepted send writes the high entry, then the pause entry in ST_SEND2,
// as the memory has one write port. Any other item is done in the cycle it is
// taken. The next item can be taken in the cycle its predecessor's result is shown.
module queued_pulse_train_generator_top #(
  parameter int QUEUE_DEPTH = qptg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire qptg_pkg::in_word_t                   in_word,
  output logic                                      out_strobe,
  output qptg_pkg::out_word_t                       out_word,
  input  wire logic                                 cfg_we,
  input  wire logic [qptg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [qptg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import qptg_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W  = (CNT_W > QCNT_W) ? CNT_W : QCNT_W;
  localparam int ENT_W  = TICKS_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_LIM  = CNT_W'(QUEUE_DEPTH - 2);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEND2
  } state_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  // Configuration registers.
  logic [TIME_W-1:0]  dead_time_r;
  logic [TICKS_W-1:0] pause_r;

  // Control and timing state.
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TICKS_W-1:0] countdown_r, countdown_nxt;
  logic               cur_high_r, cur_high_nxt;
  logic [TIME_W-1:0]  last_send_r, last_send_nxt;
  logic               pin_r, pin_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_word_t          out_word_r, out_word_nxt;

  // Queue memory access.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;

  logic               accept;
  logic [TIME_W-1:0]  shifted_time;
  logic               send_ok;
  logic [STAT_W-1:0]  status;
  logic [EXT_W-1:0]   count_ext;

  assign accept       = start && (state_r == ST_IDLE);
  assign shifted_time = in_word.time_us - dead_time_r;
  assign send_ok      = shifted_time > last_send_r;

  qptg_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    count_nxt      = count_r;
    countdown_nxt  = countdown_r;
    cur_high_nxt   = cur_high_r;
    last_send_nxt  = last_send_r;
    pin_nxt        = pin_r;
    out_strobe_nxt = 1'b0;
    status         = STAT_NONE;
    ram_we         = 1'b0;
    ram_waddr      = wr_idx_r;
    ram_wdata      = {1'b1, in_word.pulse_ticks};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_strobe_nxt = 1'b1;
          unique case (in_word.cmd)
            CMD_TICK: begin
              if (countdown_r != '0) begin
                countdown_nxt = countdown_r - 1'b1;
              end else if (count_r != '0) begin
                // The entry at the read index comes out of the memory next cycle.
                state_nxt      = ST_POP;
                out_strobe_nxt = 1'b0;
              end else if (cur_high_r) begin
                pin_nxt = 1'b0;
              end
            end
            CMD_SEND: begin
              if (!send_ok) begin
                status = STAT_DEAD;
              end else if (count_r > FULL_LIM) begin
                status = STAT_FULL;
              end else begin
                // High entry now, the pause entry in the next cycle.
                ram_we         = 1'b1;
                wr_idx_nxt     = next_idx(wr_idx_r);
                count_nxt      = count_r + 1'b1;
                last_send_nxt  = in_word.time_us;
                state_nxt      = ST_SEND2;
                out_strobe_nxt = 1'b0;
              end
            end
            CMD_CLEAR: begin
              rd_idx_nxt = '0;
              wr_idx_nxt = '0;
              count_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        countdown_nxt  = ram_rdata[TICKS_W-1:0];
        cur_high_nxt   = ram_rdata[TICKS_W];
        if (ram_rdata[TICKS_W]) begin
          pin_nxt = 1'b1;
        end else if (cur_high_r) begin
          pin_nxt = 1'b0;
        end
        rd_idx_nxt     = next_idx(rd_idx_r);
        count_nxt      = count_r - 1'b1;
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
      end
      ST_SEND2: begin
        ram_we         = 1'b1;
        ram_wdata      = {1'b0, pause_r};
        wr_idx_nxt     = next_idx(wr_idx_r);
        count_nxt      = count_r + 1'b1;
        status         = STAT_ACCEPTED;
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    count_ext                 = EXT_W'(count_nxt);
    out_word_nxt.pin_level    = pin_nxt;
    out_word_nxt.send_status  = status;
    out_word_nxt.queue_count  = count_ext[QCNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      count_r      <= '0;
      countdown_r  <= '0;
      cur_high_r   <= 1'b1;
      last_send_r  <= '0;
      pin_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      wr_idx_r     <= wr_idx_nxt;
      count_r      <= count_nxt;
      countdown_r  <= countdown_nxt;
      cur_high_r   <= cur_high_nxt;
      last_send_r  <= last_send_nxt;
      pin_r        <= pin_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_time_r <= '0;
      pause_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_TIME:   dead_time_r <= cfg_wdata[TIME_W-1:0];
        CFG_PAUSE_TICKS: pause_r     <= cfg_wdata[TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`include "queued_pulse_train_generator_top_assert.svh"

  `QPTG_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_CNT)
  `QPTG_ASSERT_NEXT(a_item_progress, clk, rst_n, accept, busy || out_strobe_r)
  `QPTG_ASSERT_NEXT(a_pop_result, clk, rst_n, state_r == ST_POP, out_strobe_r && !busy)
  `QPTG_ASSERT_NEXT(a_send_result, clk, rst_n, state_r == ST_SEND2,
                    out_strobe_r && out_word_r.send_status == STAT_ACCEPTED)
  `QPTG_ASSERT_SAME(a_no_result_busy, clk, rst_n, busy, !out_strobe_r)

endmodule

`default_nettype wire
